// File: src/buart_pkg.sv
// shared types and constants for the buffered uart transmitter
// no dependencies; imported by buffered_uart_transmitter_top, its checker and its test
`default_nettype none

package buart_pkg;

    // item operation codes
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_NONE     = 2'd0,
        STATUS_ACCEPTED = 2'd1,
        STATUS_BUSY     = 2'd2,
        STATUS_OVERFLOW = 2'd3
    } status_t;

    localparam int unsigned DATA_BITS       = 8;
    localparam logic [7:0]  PERIOD_RESET    = 8'd8;
    localparam int unsigned COUNT_W         = 5;
    localparam int unsigned BIT_IDX_W       = 3;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT = 3'd7;

    // input transaction payload
    typedef struct packed {
        op_t                  op;
        logic [DATA_BITS-1:0] data;
        logic                 last;
    } in_item_t;

    // result transaction payload
    typedef struct packed {
        logic    tx_line;
        logic    busy_res;
        status_t status;
    } out_item_t;

endpackage

`default_nettype wire

// File: src/buffered_uart_transmitter_top.sv
// buffered 8N1 serial transmitter driven by tick transactions
// an accepted item's result is loaded into the output register in the next cycle
// throughput: one item per cycle while the output is not stalled; the output register is reloaded while it drains
// reset: rst_n asynchronous, line idle high, bit period 8, no message pending
// depends on buart_pkg
`default_nettype none

module buffered_uart_transmitter_top #(
    parameter int unsigned MESSAGE_BYTES = 16
) (
    input  wire                   clk,
    input  wire                   rst_n,
    // item input channel
    input  wire                   in_valid,
    output logic                  in_stall,
    input  wire buart_pkg::in_item_t   in_item,
    // result output channel
    output logic                  out_valid,
    input  wire                   out_stall,
    output buart_pkg::out_item_t  out_item,
    // bit period register write channel
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [7:0]            cfg_data
);
    import buart_pkg::*;

    localparam int unsigned IDX_W = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
    localparam logic [COUNT_W-1:0] MSG_BYTES_C = COUNT_W'(MESSAGE_BYTES);

    typedef enum logic [2:0] {
        PH_WAIT   = 3'd0,
        PH_START  = 3'd1,
        PH_DATA   = 3'd2,
        PH_STOP   = 3'd3,
        PH_FINISH = 3'd4
    } phase_t;

    // message buffer, read data registered at the byte index held after each edge
    logic [DATA_BITS-1:0] store_mem [MESSAGE_BYTES];

    logic [7:0]           period_reg;
    logic [COUNT_W-1:0]   load_count_reg,  load_count_next;
    logic [COUNT_W-1:0]   msg_len_reg,     msg_len_next;
    logic [COUNT_W-1:0]   byte_idx_reg,    byte_idx_next;
    logic [BIT_IDX_W-1:0] bit_idx_reg,     bit_idx_next;
    logic [DATA_BITS-1:0] shift_reg,       shift_next;
    phase_t               phase_reg,       phase_next;
    logic [7:0]           tick_reg,        tick_next;
    logic                 line_reg,        line_next;
    logic                 out_valid_reg;
    out_item_t            out_item_reg,    out_item_next;
    logic [DATA_BITS-1:0] store_rd_reg;

    logic                 accept;
    logic                 store_we;
    logic [8:0]           tick_inc;
    logic [COUNT_W-1:0]   store_raddr;

    // handshakes
    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign tick_inc    = {1'b0, tick_reg} + 9'd1;
    assign store_raddr = accept ? byte_idx_next : byte_idx_reg;

    // next state for one item
    always_comb
    begin
        load_count_next = load_count_reg;
        msg_len_next    = msg_len_reg;
        byte_idx_next   = byte_idx_reg;
        bit_idx_next    = bit_idx_reg;
        shift_next      = shift_reg;
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        line_next       = line_reg;
        store_we        = 1'b0;
        out_item_next.status = STATUS_NONE;

        if (in_item.op == OP_TICK)
        begin
            // tick: count and take a frame step at the period
            if (tick_inc >= {1'b0, period_reg})
            begin
                tick_next = '0;
                if (msg_len_reg != '0)
                begin
                    case (phase_reg)
                        PH_START:
                        begin
                            line_next  = 1'b0;
                            shift_next = store_rd_reg;
                            phase_next = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            line_next  = shift_reg[0];
                            shift_next = {1'b0, shift_reg[DATA_BITS-1:1]};
                            if (bit_idx_reg == LAST_BIT)
                            begin
                                bit_idx_next  = '0;
                                byte_idx_next = byte_idx_reg + COUNT_W'(1);
                                phase_next    = PH_STOP;
                            end
                            else
                            begin
                                bit_idx_next = bit_idx_reg + BIT_IDX_W'(1);
                            end
                        end
                        PH_STOP:
                        begin
                            line_next  = 1'b1;
                            phase_next = (byte_idx_reg >= msg_len_reg) ? PH_FINISH : PH_START;
                        end
                        PH_FINISH:
                        begin
                            phase_next    = PH_WAIT;
                            msg_len_next  = '0;
                            byte_idx_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            else
            begin
                tick_next = tick_inc[7:0];
            end
        end
        else if (msg_len_reg != '0)
        begin
            // load refused while sending
            out_item_next.status = STATUS_BUSY;
        end
        else if (load_count_reg >= MSG_BYTES_C)
        begin
            // buffer full, drop the message
            out_item_next.status = STATUS_OVERFLOW;
            if (in_item.last)
            begin
                load_count_next = '0;
            end
        end
        else
        begin
            // buffer the byte, start sending on last
            store_we             = 1'b1;
            load_count_next      = load_count_reg + COUNT_W'(1);
            out_item_next.status = STATUS_ACCEPTED;
            if (in_item.last)
            begin
                msg_len_next    = load_count_reg + COUNT_W'(1);
                load_count_next = '0;
                byte_idx_next   = '0;
                bit_idx_next    = '0;
                phase_next      = PH_START;
            end
        end

        out_item_next.tx_line  = line_next;
        out_item_next.busy_res = (msg_len_next != '0);
    end

    // message buffer write and registered read, new byte forwarded on a same-address write
    always_ff @(posedge clk)
    begin
        if (accept && store_we)
        begin
            store_mem[load_count_reg[IDX_W-1:0]] <= in_item.data;
        end
        if (accept && store_we && (load_count_reg == store_raddr))
        begin
            store_rd_reg <= in_item.data;
        end
        else if (store_raddr < MSG_BYTES_C)
        begin
            store_rd_reg <= store_mem[store_raddr[IDX_W-1:0]];
        end
        else
        begin
            store_rd_reg <= '0;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // control state and transmitter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= PERIOD_RESET;
            load_count_reg <= '0;
            msg_len_reg    <= '0;
            byte_idx_reg   <= '0;
            bit_idx_reg    <= '0;
            shift_reg      <= '0;
            phase_reg      <= PH_WAIT;
            tick_reg       <= '0;
            line_reg       <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                period_reg <= cfg_data;
            end
            if (accept)
            begin
                load_count_reg <= load_count_next;
                msg_len_reg    <= msg_len_next;
                byte_idx_reg   <= byte_idx_next;
                bit_idx_reg    <= bit_idx_next;
                shift_reg      <= shift_next;
                phase_reg      <= phase_next;
                tick_reg       <= tick_next;
                line_reg       <= line_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: tb/buffered_uart_transmitter_checker.sv
// result checker for the buffered uart transmitter: watches the item, result and
// bit period channels, predicts each result and compares it field by field
// depends on buart_pkg
`default_nettype none

module buffered_uart_transmitter_checker #(
    parameter int unsigned MESSAGE_BYTES = 16
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    input  wire                   in_stall,
    input  wire buart_pkg::in_item_t   in_item,
    input  wire                   out_valid,
    input  wire                   out_stall,
    input  wire buart_pkg::out_item_t  out_item,
    input  wire                   cfg_valid,
    input  wire                   cfg_ready,
    input  wire  [7:0]            cfg_data,
    output int                    mismatch_count,
    output int                    results_due
);
    timeunit 1ns;
    timeprecision 1ps;
    import buart_pkg::*;

    typedef enum logic [2:0] {
        FRAME_WAIT   = 3'd0,
        FRAME_START  = 3'd1,
        FRAME_DATA   = 3'd2,
        FRAME_STOP   = 3'd3,
        FRAME_FINISH = 3'd4
    } frame_phase_t;

    // transmitter state as the block should hold it
    logic [7:0]           period_q;
    logic [7:0]           message_mem [MESSAGE_BYTES];
    logic [COUNT_W-1:0]   fill_count;
    logic [COUNT_W-1:0]   tx_length;
    logic [COUNT_W-1:0]   byte_pos;
    logic [BIT_IDX_W-1:0] bit_pos;
    logic [7:0]           shift_q;
    frame_phase_t         phase_q;
    logic [7:0]           tick_q;
    logic                 line_q;

    out_item_t line_reports_due [$];
    int fails = 0;
    int due_count = 0;

    assign mismatch_count = fails;
    assign results_due    = due_count;

    // one step of the serial frame, taken once per bit period
    function automatic void advance_frame();
        if (tx_length == '0)
            return;
        case (phase_q)
            FRAME_START:
            begin
                line_q  = 1'b0;
                shift_q = (byte_pos < MESSAGE_BYTES) ? message_mem[byte_pos] : 8'd0;
                phase_q = FRAME_DATA;
            end
            FRAME_DATA:
            begin
                line_q  = shift_q[0];
                shift_q = shift_q >> 1;
                if (bit_pos == LAST_BIT)
                begin
                    bit_pos  = '0;
                    byte_pos = byte_pos + 1'b1;
                    phase_q  = FRAME_STOP;
                end
                else
                    bit_pos = bit_pos + 1'b1;
            end
            FRAME_STOP:
            begin
                line_q  = 1'b1;
                phase_q = (byte_pos >= tx_length) ? FRAME_FINISH : FRAME_START;
            end
            FRAME_FINISH:
            begin
                phase_q   = FRAME_WAIT;
                tx_length = '0;
                byte_pos  = '0;
            end
            default: ;
        endcase
    endfunction

    // line level, busy flag and status that one item leaves behind
    function automatic out_item_t next_line_report(input in_item_t item);
        out_item_t  report;
        logic [8:0] tick_next;
        status_t    st;
        st = STATUS_NONE;
        if (item.op == OP_TICK)
        begin
            tick_next = {1'b0, tick_q} + 9'd1;
            if (tick_next >= {1'b0, period_q})
            begin
                tick_q = '0;
                advance_frame();
            end
            else
                tick_q = tick_next[7:0];
        end
        else if (tx_length != '0)
            st = STATUS_BUSY;
        else if (fill_count >= MESSAGE_BYTES)
        begin
            // buffer full: drop, and forget the whole message at its last byte
            st = STATUS_OVERFLOW;
            if (item.last)
                fill_count = '0;
        end
        else
        begin
            message_mem[fill_count] = item.data;
            fill_count = fill_count + 1'b1;
            st = STATUS_ACCEPTED;
            if (item.last)
            begin
                tx_length  = fill_count;
                fill_count = '0;
                byte_pos   = '0;
                bit_pos    = '0;
                phase_q    = FRAME_START;
            end
        end
        report.tx_line  = line_q;
        report.busy_res = (tx_length != '0);
        report.status   = st;
        return report;
    endfunction

    // watch the three channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t due;
        if (!rst_n)
        begin
            period_q   = PERIOD_RESET;
            fill_count = '0;
            tx_length  = '0;
            byte_pos   = '0;
            bit_pos    = '0;
            shift_q    = '0;
            phase_q    = FRAME_WAIT;
            tick_q     = '0;
            line_q     = 1'b1;
            for (int i = 0; i < MESSAGE_BYTES; i++)
                message_mem[i] = 8'd0;
            line_reports_due.delete();
            due_count = 0;
        end
        else
        begin
            // result transaction against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (line_reports_due.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result expected none actual %0b/%0b/%0d",
                             $time, out_item.tx_line, out_item.busy_res, out_item.status);
                end
                else
                begin
                    due = line_reports_due.pop_front();
                    if (out_item.tx_line !== due.tx_line)
                    begin
                        fails++;
                        $display("%0t: tx_line expected %0b actual %0b",
                                 $time, due.tx_line, out_item.tx_line);
                    end
                    if (out_item.busy_res !== due.busy_res)
                    begin
                        fails++;
                        $display("%0t: busy_res expected %0b actual %0b",
                                 $time, due.busy_res, out_item.busy_res);
                    end
                    if (out_item.status !== due.status)
                    begin
                        fails++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, due.status, out_item.status);
                    end
                end
            end
            // bit period write
            if (cfg_valid && cfg_ready)
                period_q = cfg_data;
            // item transaction
            if (in_valid && !in_stall)
                line_reports_due.push_back(next_line_report(in_item));
            due_count = line_reports_due.size();
        end
    end

endmodule

`default_nettype wire

// File: tb/buffered_uart_transmitter_top_test.sv
// stimulus and verdict for buffered_uart_transmitter_top: messages, ticks and noise
// under several bit periods, with random idling and a long result hold-off
// depends on buart_pkg, buffered_uart_transmitter_top and buffered_uart_transmitter_checker
`default_nettype none

module buffered_uart_transmitter_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import buart_pkg::*;

    localparam int unsigned MESSAGE_BYTES = 16;
    localparam int unsigned HOLD_CYCLES   = 200;
    localparam int unsigned IDLE_PERCENT  = 31;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    in_item_t   in_item   = '0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data  = 8'd0;
    logic       in_stall;
    logic       out_valid;
    logic       cfg_ready;
    out_item_t  out_item;

    bit         idle_on    = 1'b1;
    bit         hold_req   = 1'b0;
    int         items_sent = 0;
    logic [7:0] period_now = PERIOD_RESET;
    int         mismatch_count;
    int         results_due;

    buffered_uart_transmitter_top #(
        .MESSAGE_BYTES (MESSAGE_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    buffered_uart_transmitter_checker #(
        .MESSAGE_BYTES (MESSAGE_BYTES)
    ) line_monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_item       (out_item),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // result side stall: random gaps, or one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // one item transaction, with random idle cycles ahead of it
    task automatic send_item(input op_t op, input logic [7:0] data, input logic last);
        in_item_t item;
        item.op   = op;
        item.data = data;
        item.last = last;
        if (idle_on)
        begin
            while ($urandom_range(0, 99) < IDLE_PERCENT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // tick with random content in the ignored fields
    task automatic send_tick();
        send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // a whole message, then about enough ticks to get it out on the line
    task automatic send_message();
        int unsigned per_bit, r, len, frames, n_ticks;
        per_bit = (period_now == 8'd0) ? 1 : period_now;
        r = $urandom_range(0, 99);
        if (r < 60 || (r < 85 && per_bit > 2))
            len = $urandom_range(1, 3);
        else if (r < 85)
            len = $urandom_range(4, MESSAGE_BYTES - 1);
        else
            len = $urandom_range((per_bit > 2) ? MESSAGE_BYTES + 1 : MESSAGE_BYTES,
                                 MESSAGE_BYTES + 3);
        for (int i = 0; i < len; i++)
            send_item(OP_LOAD, 8'($urandom_range(0, 255)), i == len - 1);
        // start, eight data and stop steps per byte plus the finish step
        frames  = (len > MESSAGE_BYTES) ? 0 : len;
        n_ticks = per_bit * (10 * frames + 2) + $urandom_range(0, 2 * per_bit);
        if ($urandom_range(0, 9) == 0)
            n_ticks = $urandom_range(0, n_ticks);
        for (int t = 0; t < n_ticks; t++)
        begin
            // loads while busy should be refused
            if (t < n_ticks / 2 && $urandom_range(0, 19) == 0)
                send_item(OP_LOAD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
                send_tick();
        end
    endtask

    // short burst of random items
    task automatic send_noise();
        int unsigned n;
        n = $urandom_range(1, 8);
        repeat (n)
            send_item(op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      $urandom_range(0, 9) < 3);
    endtask

    task automatic run_phase(input int unsigned quota);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            if ($urandom_range(0, 99) < 70)
                send_message();
            else
                send_noise();
        end
    endtask

    // hold the input until every result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
    endtask

    task automatic write_period(input logic [7:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        period_now = value;
    endtask

    // main sequence
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme bytes, refusal while busy, ignored tick fields, zero period
        send_item(OP_LOAD, 8'h00, 1'b0);
        send_item(OP_LOAD, 8'hFF, 1'b1);
        send_item(OP_LOAD, 8'hA5, 1'b1);
        send_item(OP_LOAD, 8'h5A, 1'b0);
        repeat (10)
            send_item(OP_TICK, 8'hFF, 1'b1);
        send_item(OP_TICK, 8'h00, 1'b0);
        write_period(8'd0);
        repeat (6)
            send_tick();

        // fastest period with no idling on either side
        write_period(8'd1);
        idle_on = 1'b0;
        run_phase(120);
        idle_on = 1'b1;

        write_period(PERIOD_RESET);
        run_phase(60);

        // slowest period, then cut over mid-frame by the next write
        write_period(8'd255);
        send_item(OP_LOAD, 8'($urandom_range(0, 255)), 1'b1);
        repeat (400)
            send_tick();

        // long result hold-off fills the block and stalls the input
        write_period(8'd2);
        hold_req = 1'b1;
        run_phase(120);

        write_period(8'($urandom_range(3, 6)));
        run_phase(80);

        write_period(8'd0);
        run_phase(80);

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && results_due == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
